FILE: sv/mfa_pkg.sv
// package: shared types, constants and activation tables for mlp_forward_argmax
package mfa_pkg;

  localparam int MAX_LAYERS   = 4;
  localparam int MAX_NEURONS  = 64;
  localparam int VALUE_BITS   = 16;
  localparam int NIDX_BITS    = $clog2(MAX_NEURONS);
  localparam int STAGE_BITS   = 2;
  localparam int WEIGHT_DEPTH = (MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS;
  localparam int BIAS_DEPTH   = (MAX_LAYERS - 1) * MAX_NEURONS;
  localparam int NEURON_DEPTH = 2 * MAX_NEURONS;
  localparam int WADDR_BITS   = $clog2(WEIGHT_DEPTH);
  localparam int BADDR_BITS   = $clog2(BIAS_DEPTH);
  localparam int NADDR_BITS   = $clog2(NEURON_DEPTH);
  localparam int ACC_BITS     = 2 * VALUE_BITS + NIDX_BITS + 2;
  localparam int CFG_BITS     = 7;
  localparam int REG_BITS     = 3;

  localparam logic [1:0] FUNC_WEIGHT = 2'd0;
  localparam logic [1:0] FUNC_BIAS   = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;

  localparam logic [1:0] ACT_SIGMOID = 2'd0;
  localparam logic [1:0] ACT_TANH    = 2'd1;
  localparam logic [1:0] ACT_RELU    = 2'd2;

  localparam logic [REG_BITS-1:0] REG_LAYER_COUNT = 3'd0;
  localparam logic [REG_BITS-1:0] REG_WIDTH_FIRST = 3'd1;
  localparam logic [REG_BITS-1:0] REG_WIDTH_SECOND = 3'd2;
  localparam logic [REG_BITS-1:0] REG_WIDTH_THIRD = 3'd3;
  localparam logic [REG_BITS-1:0] REG_WIDTH_FOURTH = 3'd4;
  localparam logic [REG_BITS-1:0] REG_ACTIVATION = 3'd5;

  typedef struct packed {
    logic [1:0]                 func;
    logic [1:0]                 stage;
    logic [5:0]                 dest_index;
    logic [5:0]                 source_index;
    logic signed [15:0]         value;
    logic                       last;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]         predicted_class;
    logic signed [15:0] best_score;
  } out_beat_t;

  // settings the engine reads, already clamped
  typedef struct packed {
    logic [2:0]           layers;
    logic [6:0]           width0;
    logic [6:0]           width1;
    logic [6:0]           width2;
    logic [6:0]           width3;
    logic [1:0]           act;
  } eng_cfg_t;

  // exp(-k/64) in Q32, built by repeated truncated products
  function automatic logic [63:0] exp_q32(input int k);
    logic [63:0] e;
    e = 64'h1_0000_0000;
    for (int i = 0; i < k; i++) e = (e * 64'd4228380000) >> 32;
    return e;
  endfunction

  // restoring division, only evaluated while the tables are built
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] dv);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, dv}) begin
        r = r - {1'b0, dv};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [15:0] sig_entry(input int i);
    int m;
    int a;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    m = 2 * i + 1 - 512;
    a = (m < 0) ? -m : m;
    e = exp_q32(a);
    den = 64'h1_0000_0000 + e;
    num = (m >= 0) ? 64'h1_0000_0000 : e;
    return 16'(udiv64(64'd8192 * num + den, 64'd2 * den));
  endfunction

  function automatic logic signed [15:0] tanh_entry(input int i);
    int m;
    int a;
    logic [63:0] e2;
    logic [63:0] den2;
    logic [63:0] t;
    m = 2 * i + 1 - 512;
    a = (m < 0) ? -m : m;
    e2 = exp_q32(2 * a);
    den2 = 64'h1_0000_0000 + e2;
    t = udiv64(64'd8192 * (64'h1_0000_0000 - e2) + den2, 64'd2 * den2);
    return (m >= 0) ? 16'(t) : 16'(-t);
  endfunction

  typedef logic signed [15:0] table_t [512];

  function automatic table_t build_sig();
    table_t t;
    for (int i = 0; i < 512; i++) t[i] = sig_entry(i);
    return t;
  endfunction

  function automatic table_t build_tanh();
    table_t t;
    for (int i = 0; i < 512; i++) t[i] = tanh_entry(i);
    return t;
  endfunction

  localparam table_t SIG_TABLE  = build_sig();
  localparam table_t TANH_TABLE = build_tanh();

endpackage

FILE: sv/mfa_ram.sv
// generic single-port-write, single-read synchronous ram
module mfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/mfa_act.sv
// rounding, saturation and activation of one accumulated sum (registered)
module mfa_act (
  input  logic                                clk,
  input  logic                                en,
  input  logic [1:0]                          act,
  input  logic signed [mfa_pkg::ACC_BITS-1:0] acc,
  output logic signed [15:0]                  result
);
  import mfa_pkg::*;

  logic signed [ACC_BITS-1:0] q;
  logic signed [15:0]         sat;
  logic [8:0]                 idx;
  logic signed [15:0]         act_val;

  always_comb begin
    q = (acc + ACC_BITS'(2048)) >>> 12;
    if (q > ACC_BITS'(32767)) begin
      sat = 16'sh7fff;
    end else if (q < -ACC_BITS'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = q[15:0];
    end
    idx = {~sat[15], sat[14:7]};
    case (act)
      ACT_SIGMOID: act_val = SIG_TABLE[idx];
      ACT_TANH:    act_val = TANH_TABLE[idx];
      ACT_RELU:    act_val = sat[15] ? 16'sd0 : sat;
      default:     act_val = sat;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= act_val;
    end
  end

endmodule

FILE: sv/mfa_engine.sv
// sequencer: multiply-accumulate over memories, layer by layer, then argmax
module mfa_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  mfa_pkg::eng_cfg_t           cfg,
  output logic                        busy,
  output logic [mfa_pkg::WADDR_BITS-1:0] w_raddr,
  input  logic signed [15:0]          w_rdata,
  output logic [mfa_pkg::BADDR_BITS-1:0] b_raddr,
  input  logic signed [15:0]          b_rdata,
  output logic [mfa_pkg::NADDR_BITS-1:0] n_raddr,
  input  logic signed [15:0]          n_rdata,
  output logic                        n_we,
  output logic [mfa_pkg::NADDR_BITS-1:0] n_waddr,
  output logic signed [15:0]          n_wdata,
  output logic                        res_valid,
  input  logic                        res_ready,
  output mfa_pkg::out_beat_t          res
);
  import mfa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_ARG  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]            state;
  logic [1:0]            stage;
  logic                  bank;
  logic [NIDX_BITS-1:0]  d;
  logic [NIDX_BITS:0]    k;
  logic                  rd_v;
  logic                  rd_first;
  logic                  rd_last;
  logic                  dv;
  logic                  dv_first;
  logic                  dv_last;
  logic signed [31:0]    prod;
  logic                  prod_v;
  logic                  prod_last;
  logic signed [ACC_BITS-1:0] acc;
  logic                  acc_done;
  logic signed [15:0]    act_out;
  logic                  act_en;
  logic [6:0]            w_in;
  logic [6:0]            w_out;
  logic signed [15:0]    best;
  logic [5:0]            best_idx;
  logic [NIDX_BITS:0]    ak;
  logic                  a_v;
  logic [5:0]            a_idx;

  always_comb begin
    case (stage)
      2'd0:    begin w_in = cfg.width0; w_out = cfg.width1; end
      2'd1:    begin w_in = cfg.width1; w_out = cfg.width2; end
      default: begin w_in = cfg.width2; w_out = cfg.width3; end
    endcase
  end

  logic [6:0] w_final;
  always_comb begin
    case (cfg.layers)
      3'd2:    w_final = cfg.width1;
      3'd3:    w_final = cfg.width2;
      default: w_final = cfg.width3;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign w_raddr = WADDR_BITS'({stage, d, k[NIDX_BITS-1:0]});
  assign b_raddr = BADDR_BITS'({stage, d});
  assign n_raddr = (state == S_ARG) ? {bank, ak[NIDX_BITS-1:0]}
                                    : {bank, k[NIDX_BITS-1:0]};
  assign n_waddr = {~bank, d};
  assign n_wdata = act_out;
  assign n_we    = (state == S_WB);
  assign act_en  = (state == S_ACT);
  assign res_valid = (state == S_OUT);
  assign res.predicted_class = best_idx;
  assign res.best_score = best;

  mfa_act u_act (
    .clk    (clk),
    .en     (act_en),
    .act    (cfg.act),
    .acc    (acc),
    .result (act_out)
  );

  // inputs of one layer are written to the other bank only after the
  // whole sum of a neuron is done; next neuron reads the old bank
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_v <= 1'b0;
      dv <= 1'b0;
      prod_v <= 1'b0;
      acc_done <= 1'b0;
      a_v <= 1'b0;
    end else begin
      // ram data shows up in the cycle after its address
      dv <= rd_v;
      dv_first <= rd_first;
      dv_last <= rd_last;
      prod_v <= dv;
      prod_last <= dv_last;
      prod <= w_rdata * n_rdata;
      acc_done <= 1'b0;
      if (dv && dv_first) begin
        acc <= ACC_BITS'(b_rdata) <<< 12;
      end
      if (prod_v) begin
        acc <= acc + ACC_BITS'(prod);
        acc_done <= prod_last;
      end
      case (state)
        S_IDLE: begin
          rd_v <= 1'b0;
          if (start) begin
            state <= S_MAC;
            stage <= 2'd0;
            bank <= 1'b0;
            d <= '0;
            k <= '0;
            rd_v <= 1'b1;
            rd_first <= 1'b1;
            rd_last <= (cfg.width0 == 7'd1);
          end
        end
        S_MAC: begin
          rd_first <= 1'b0;
          if (rd_v && !rd_last) begin
            k <= k + 1'b1;
            rd_last <= ((k + 2'd2) == w_in);
          end else begin
            rd_v <= 1'b0;
          end
          if (acc_done) begin
            state <= S_ACT;
          end
        end
        S_ACT: begin
          state <= S_WB;
        end
        S_WB: begin
          k <= '0;
          if ({1'b0, d} + 1'b1 == w_out) begin
            d <= '0;
            bank <= ~bank;
            if ({1'b0, stage} + 2'd2 == cfg.layers) begin
              state <= S_ARG;
              ak <= '0;
              a_v <= 1'b1;
            end else begin
              stage <= stage + 1'b1;
              state <= S_MAC;
              rd_v <= 1'b1;
              rd_first <= 1'b1;
              rd_last <= (w_out == 7'd1);
            end
          end else begin
            d <= d + 1'b1;
            state <= S_MAC;
            rd_v <= 1'b1;
            rd_first <= 1'b1;
            rd_last <= (w_in == 7'd1);
          end
        end
        S_ARG: begin
          if (a_v) begin
            a_idx <= 6'(ak);
            if ((ak + 1'b1) == w_final) begin
              a_v <= 1'b0;
            end else begin
              ak <= ak + 1'b1;
            end
          end
          if (ak != '0 || !a_v) begin
            if (a_idx == 6'd0 || n_rdata > best) begin
              best <= n_rdata;
              best_idx <= a_idx;
            end
          end
          if (!a_v) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/mlp_forward_argmax.sv
// top level: fully connected network inference with argmax result
// one item at a time: a sample beat with last blocks input until the result
// is taken; weight, bias and plain sample beats are accepted back to back while idle
// reset clears control and loads register defaults; memories are not cleared
module mlp_forward_argmax (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mfa_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mfa_pkg::out_beat_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [6:0]          cfg_data
);
  import mfa_pkg::*;

  logic [2:0] layer_count;
  logic [6:0] width_first;
  logic [6:0] width_second;
  logic [6:0] width_third;
  logic [6:0] width_fourth;
  logic [1:0] activation_kind;
  eng_cfg_t   ecfg;
  logic       busy;
  logic       acc_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= 3'd3;
      width_first <= 7'd64;
      width_second <= 7'd64;
      width_third <= 7'd10;
      width_fourth <= 7'd10;
      activation_kind <= ACT_SIGMOID;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LAYER_COUNT:  layer_count <= cfg_data[2:0];
        REG_WIDTH_FIRST:  width_first <= cfg_data;
        REG_WIDTH_SECOND: width_second <= cfg_data;
        REG_WIDTH_THIRD:  width_third <= cfg_data;
        REG_WIDTH_FOURTH: width_fourth <= cfg_data;
        REG_ACTIVATION:   activation_kind <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [6:0] clamp_w(input logic [6:0] w);
    if (w == 7'd0) return 7'd1;
    if (w > 7'(MAX_NEURONS)) return 7'(MAX_NEURONS);
    return w;
  endfunction

  always_comb begin
    ecfg.layers = (layer_count < 3'd2) ? 3'd2 :
                  (layer_count > 3'd4) ? 3'd4 : layer_count;
    ecfg.width0 = clamp_w(width_first);
    ecfg.width1 = clamp_w(width_second);
    ecfg.width2 = clamp_w(width_third);
    ecfg.width3 = clamp_w(width_fourth);
    ecfg.act = activation_kind;
  end

  assign in_ready = !busy;
  assign acc_in = in_valid && in_ready;

  logic                   w_we;
  logic                   b_we;
  logic                   s_we;
  logic [WADDR_BITS-1:0]  w_raddr;
  logic [BADDR_BITS-1:0]  b_raddr;
  logic [NADDR_BITS-1:0]  n_raddr;
  logic [15:0]            w_rdata;
  logic [15:0]            b_rdata;
  logic [15:0]            n_rdata;
  logic                   e_we;
  logic [NADDR_BITS-1:0]  e_waddr;
  logic signed [15:0]     e_wdata;
  logic                   n_we;
  logic [NADDR_BITS-1:0]  n_waddr;
  logic [15:0]            n_wdata;
  logic                   start;

  assign w_we = acc_in && in_data.func == FUNC_WEIGHT && in_data.stage != 2'd3;
  assign b_we = acc_in && in_data.func == FUNC_BIAS && in_data.stage != 2'd3;
  assign s_we = acc_in && in_data.func == FUNC_SAMPLE;
  assign start = s_we && in_data.last;

  assign n_we = s_we || e_we;
  assign n_waddr = s_we ? {1'b0, in_data.source_index} : e_waddr;
  assign n_wdata = s_we ? in_data.value : e_wdata;

  mfa_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_wmem (
    .clk(clk), .we(w_we),
    .waddr(WADDR_BITS'({in_data.stage, in_data.dest_index, in_data.source_index})),
    .wdata(in_data.value), .raddr(w_raddr), .rdata(w_rdata)
  );

  mfa_ram #(.WIDTH(16), .DEPTH(BIAS_DEPTH)) u_bmem (
    .clk(clk), .we(b_we),
    .waddr(BADDR_BITS'({in_data.stage, in_data.dest_index})),
    .wdata(in_data.value), .raddr(b_raddr), .rdata(b_rdata)
  );

  mfa_ram #(.WIDTH(16), .DEPTH(NEURON_DEPTH)) u_nmem (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  mfa_engine u_eng (
    .clk(clk), .rst(rst), .start(start), .cfg(ecfg), .busy(busy),
    .w_raddr(w_raddr), .w_rdata(w_rdata),
    .b_raddr(b_raddr), .b_rdata(b_rdata),
    .n_raddr(n_raddr), .n_rdata(n_rdata),
    .n_we(e_we), .n_waddr(e_waddr), .n_wdata(e_wdata),
    .res_valid(out_valid), .res_ready(out_ready), .res(out_data)
  );

  // no new beat while a pass runs or its result waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during pass");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ready) else $error("pass did not start");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");

endmodule

FILE: tb/mlp_forward_argmax_tb.sv
// testbench for mlp_forward_argmax: random network loads and passes against a predictor
module mlp_forward_argmax_tb;
  import mfa_pkg::*;

  localparam int WD_LIMIT = 300000;
  localparam int SETTLE = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  mlp_forward_argmax i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // network copy used to predict each pass
  logic signed [15:0] wgt [3][64][64];
  logic signed [15:0] bia [3][64];
  logic signed [15:0] nv [2][64];
  logic signed [15:0] sig_lut [512];
  logic signed [15:0] tanh_lut [512];
  int n_layers = 3;
  int lw [4] = '{64, 64, 10, 10};
  logic [1:0] act_sel = ACT_SIGMOID;

  in_beat_t beat_q [$];
  out_beat_t argmax_due [$];
  out_beat_t want;
  int send_idle = 0;
  int recv_stall = 0;
  int fails = 0;
  int wd = 0;

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void make_luts();
    longint unsigned ex [1024];
    longint unsigned one, e, den, t;
    int m, a;
    one = 64'h1_0000_0000;
    ex[0] = one;
    for (int i = 1; i < 1024; i++) ex[i] = (ex[i-1] * 64'd4228380000) >> 32;
    for (int i = 0; i < 512; i++) begin
      m = 2 * i - 511;
      a = m < 0 ? -m : m;
      e = ex[a];
      den = one + e;
      t = (64'd8192 * (m >= 0 ? one : e) + den) / (64'd2 * den);
      sig_lut[i] = t[15:0];
      den = one + ex[2*a];
      t = (64'd8192 * (one - ex[2*a]) + den) / (64'd2 * den);
      tanh_lut[i] = m >= 0 ? t[15:0] : -t[15:0];
    end
  endfunction

  function automatic logic signed [15:0] activate(logic signed [15:0] s);
    logic [15:0] ofs;
    ofs = s + 16'sh8000;
    case (act_sel)
      ACT_SIGMOID: return sig_lut[ofs[15:7]];
      ACT_TANH: return tanh_lut[ofs[15:7]];
      ACT_RELU: return s < 0 ? 16'sd0 : s;
      default: return s;
    endcase
  endfunction

  function automatic void run_pass();
    logic signed [15:0] nxt [64];
    longint acc;
    int bank;
    out_beat_t r;
    bank = 0;
    for (int s = 0; s + 1 < n_layers; s++) begin
      for (int d = 0; d < lw[s+1]; d++) begin
        acc = longint'(bia[s][d]) <<< 12;
        for (int k = 0; k < lw[s]; k++) acc += longint'(wgt[s][d][k]) * longint'(nv[bank][k]);
        acc = (acc + 2048) >>> 12;
        acc = acc > 32767 ? 32767 : (acc < -32768 ? -32768 : acc);
        nxt[d] = activate(acc[15:0]);
      end
      bank ^= 1;
      for (int d = 0; d < lw[s+1]; d++) nv[bank][d] = nxt[d];
    end
    r.predicted_class = '0;
    r.best_score = nv[bank][0];
    for (int k = 1; k < lw[n_layers-1]; k++)
      if (nv[bank][k] > r.best_score) begin
        r.best_score = nv[bank][k];
        r.predicted_class = k[5:0];
      end
    argmax_due = {argmax_due, r};
  endfunction

  function automatic void absorb_beat(in_beat_t b);
    case (b.func)
      FUNC_WEIGHT: if (b.stage != 2'd3) wgt[b.stage][b.dest_index][b.source_index] = b.value;
      FUNC_BIAS: if (b.stage != 2'd3) bia[b.stage][b.dest_index] = b.value;
      FUNC_SAMPLE: begin
        nv[0][b.source_index] = b.value;
        if (b.last) run_pass();
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) absorb_beat(in_data);
      if (!in_valid || in_ready) begin
        if (beat_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_data <= beat_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (argmax_due.size() == 0) begin
          $error("result beat with nothing expected: class %0d score %0d",
                 out_data.predicted_class, out_data.best_score);
          fails++;
        end else begin
          want = argmax_due.pop_front();
          if (out_data.predicted_class !== want.predicted_class) begin
            $error("predicted_class: expected %0d actual %0d",
                   want.predicted_class, out_data.predicted_class);
            fails++;
          end
          if (out_data.best_score !== want.best_score) begin
            $error("best_score: expected %0d actual %0d", want.best_score, out_data.best_score);
            fails++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // watchdog: only counts while work is outstanding
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (beat_q.size() == 0 && !in_valid && argmax_due.size() == 0)) begin
      wd <= 0;
    end else if (wd >= WD_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      wd <= wd + 1;
    end
  end

  function automatic logic [15:0] rand_val();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(4096) - 2048);
      default: return 16'($urandom_range(16384) - 8192);
    endcase
  endfunction

  function automatic void push(logic [1:0] f, logic [1:0] st, int d, int s,
                               logic [15:0] v, logic lst);
    in_beat_t b;
    b.func = f;
    b.stage = st;
    b.dest_index = d[5:0];
    b.source_index = s[5:0];
    b.value = v;
    b.last = lst;
    beat_q = {beat_q, b};
  endfunction

  task automatic wait_idle();
    do @(posedge clk); while (beat_q.size() > 0 || in_valid || argmax_due.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[6:0];
    case (idx)
      REG_LAYER_COUNT: n_layers = clampi(val & 7, 2, 4);
      REG_WIDTH_FIRST: lw[0] = clampi(val & 127, 1, 64);
      REG_WIDTH_SECOND: lw[1] = clampi(val & 127, 1, 64);
      REG_WIDTH_THIRD: lw[2] = clampi(val & 127, 1, 64);
      REG_WIDTH_FOURTH: lw[3] = clampi(val & 127, 1, 64);
      default: act_sel = val[1:0];
    endcase
  endtask

  // layers, four widths, activation, sender idle, receiver stall
  int plan [9][8] = '{
    '{2, 3, 2, 1, 1, 0, 0, 0},
    '{2, 4, 3, 9, 9, 0, 0, 0},
    '{3, 5, 4, 6, 1, 1, 55, 0},
    '{4, 1, 32, 1, 32, 2, 0, 55},
    '{2, 32, 2, 5, 5, 3, 26, 26},
    '{0, 0, 127, 3, 2, 2, 0, 0},
    '{3, 8, 8, 8, 1, 0, 55, 55},
    '{4, 6, 5, 4, 3, 1, 26, 26},
    '{2, 3, 5, 1, 1, 2, 0, 0}
  };

  initial begin
    int base;
    make_luts();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 9; p++) begin
      wait_idle();
      for (int r = 0; r < 6; r++) write_reg(r[2:0], plan[p][r]);
      @(posedge clk);
      cfg_we <= 1'b0;
      send_idle = plan[p][6];
      recv_stall = plan[p][7];
      base = beat_q.size();
      for (int s = 0; s + 1 < n_layers; s++)
        for (int d = 0; d < lw[s+1]; d++) begin
          push(FUNC_BIAS, s[1:0], d, $urandom_range(63), rand_val(), 1'b0);
          for (int k = 0; k < lw[s]; k++) push(FUNC_WEIGHT, s[1:0], d, k, rand_val(), 1'b0);
        end
      if (p == 0) begin
        // extremes and ignored items
        push(FUNC_WEIGHT, 2'd0, 0, 0, 16'h8000, 1'b1);
        push(FUNC_WEIGHT, 2'd0, 1, 2, 16'h7fff, 1'b0);
        push(FUNC_BIAS, 2'd0, 0, 63, 16'h7fff, 1'b1);
        push(FUNC_BIAS, 2'd0, 1, 0, 16'h8000, 1'b0);
        push(2'd3, 2'd3, 63, 63, 16'hffff, 1'b1);
        push(FUNC_WEIGHT, 2'd3, 63, 63, 16'h1234, 1'b0);
        push(FUNC_BIAS, 2'd3, 63, 0, 16'h4321, 1'b0);
        push(FUNC_SAMPLE, 2'd0, 0, 0, 16'h8000, 1'b0);
        push(FUNC_SAMPLE, 2'd0, 0, 1, 16'h7fff, 1'b0);
        push(FUNC_SAMPLE, 2'd3, 63, 2, 16'h0000, 1'b1);
        push(FUNC_SAMPLE, 2'd0, 0, 63, 16'h7fff, 1'b0);
        push(FUNC_SAMPLE, 2'd0, 0, 0, 16'h7fff, 1'b0);
        push(FUNC_SAMPLE, 2'd0, 0, 1, 16'h7fff, 1'b0);
        push(FUNC_SAMPLE, 2'd0, 0, 2, 16'h8000, 1'b1);
      end
      do begin
        repeat ($urandom_range(3)) begin
          int s;
          s = $urandom_range(n_layers - 2);
          if ($urandom_range(1))
            push(FUNC_WEIGHT, s[1:0], $urandom_range(lw[s+1] - 1), $urandom_range(lw[s] - 1),
                 rand_val(), 1'($urandom_range(1)));
          else
            push(FUNC_BIAS, s[1:0], $urandom_range(lw[s+1] - 1), $urandom, rand_val(),
                 1'($urandom_range(1)));
        end
        if ($urandom_range(9) == 0)
          push(2'd3, 2'($urandom), $urandom, $urandom, 16'($urandom), 1'($urandom));
        if ($urandom_range(9) == 0)
          push(2'($urandom_range(1)), 2'd3, $urandom, $urandom, 16'($urandom), 1'b0);
        for (int k = 0; k < lw[0]; k++) begin
          if (k == lw[0] - 1 && lw[0] < 64 && $urandom_range(7) == 0)
            push(FUNC_SAMPLE, 2'($urandom), $urandom, $urandom_range(63, lw[0]), rand_val(),
                 1'b0);
          push(FUNC_SAMPLE, 2'($urandom), $urandom, k, rand_val(), k == lw[0] - 1);
        end
        // hold the sender until the pass has answered
        if ($urandom_range(3) == 0) wait_idle();
      end while (beat_q.size() - base < 60);
    end
    wait_idle();
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/mfa_pkg.sv
sv/mfa_ram.sv
sv/mfa_act.sv
sv/mfa_engine.sv
sv/mlp_forward_argmax.sv
tb/mlp_forward_argmax_tb.sv
